### design/whfs_pkg.sv
// Shared codes, command and status types for the wave height field step unit.
package whfs_pkg;

   localparam int KW  = 18;
   localparam int TSW = 16;

   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_DISTURB = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;
   // unused mode value, handled as a read
   localparam logic [1:0] MODE_SPARE   = 2'd3;

   localparam logic [1:0] REG_K_PREV     = 2'd0;
   localparam logic [1:0] REG_K_CENTER   = 2'd1;
   localparam logic [1:0] REG_K_NEIGHBOR = 2'd2;
   localparam logic [1:0] REG_TIME_STEP  = 2'd3;

   localparam logic signed [KW-1:0] K_PREV_RST     = -18'sd16384;
   localparam logic signed [KW-1:0] K_CENTER_RST   = 18'sd16384;
   localparam logic signed [KW-1:0] K_NEIGHBOR_RST = 18'sd4096;
   localparam logic [TSW-1:0]       TIME_STEP_RST  = 16'd30;

   // last sub-step index of each read sequence
   localparam logic [2:0] SUB_UPD_LAST  = 3'd4;
   localparam logic [2:0] SUB_SLP_LAST  = 3'd3;
   localparam logic [2:0] SUB_DIST_LAST = 3'd4;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_UPD,
      RD_SLP,
      RD_DIST,
      RD_ITEM
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       tick_upd;
      logic       clr_wr;
      rd_sel_type rd_sel;
      logic       sub_clr;
      logic       sub_inc;
      logic       pt_init;
      logic       pt_inc;
      logic       mul;
      logic       sum;
      logic       upd_wr;
      logic       swap;
      logic       set_oor;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       trigger;
      logic       in_range;
      logic       pt_last;
      logic       clr_last;
      logic       out_busy;
      logic [2:0] sub_idx;
   } stat_type;

endpackage

### design/wave_height_field_step_unit.sv
// Top level of the damped 2D wave height field step unit.
//
// Input words arrive on the req_ stream: req_tuser is the mode (tick, disturb,
// read), req_tdata carries elapsed time, row, column and disturb amount. Every
// input word yields exactly one result word on the rsp_ stream with the height
// and stored slopes at the given point, plus stepped and out_of_range flags.
// Weights and the time step are written on the csr_ port; the user must do so
// only while the unit idles, as the block itself does not enforce it.
//
// One word is in flight at a time. A disturb is five read-modify-write steps
// through the single read port of the current height bank. A tick that
// triggers a grid update sweeps all interior points twice, once for the
// update (five reads, wait, multiply, sum, write) and once for the slope pass.
// After reset the unit clears both height banks and both slope stores, one
// address per cycle, with req_tready low. If the receiver stalls, the result
// is held in the output register; the next word may be accepted and worked
// on, and waits before its report until the slot frees.
module wave_height_field_step_unit
   import whfs_pkg::*;
#(
   parameter int ROWS        = 128,
   parameter int COLS        = 128,
   parameter int HEIGHT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   // tdata: elapsed_time[15:0], row_index[22:16], col_index[29:23],
   //        disturb_amount[45:30], zero pad [47:46]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: height[15:0], slope_x[32:16], slope_z[49:33], zero pad [55:50]
   output logic [55:0]   rsp_tdata,
   // tuser: stepped[0], out_of_range[1]
   output logic [1:0]    rsp_tuser,
   input  logic          csr_wen,
   input  logic [1:0]    csr_addr,
   input  logic [KW-1:0] csr_wdata
);

   cmd_type            cmd;
   stat_type           stat;
   logic signed [15:0] height;
   logic signed [16:0] slope_x, slope_z;
   logic               stepped, out_of_range;

   whfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   whfs_datapath #(
      .ROWS        (ROWS),
      .COLS        (COLS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .item_mode    (req_tuser),
      .item_elapsed (req_tdata[15:0]),
      .item_row     (req_tdata[22:16]),
      .item_col     (req_tdata[29:23]),
      .item_amount  ($signed(req_tdata[45:30])),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_height   (height),
      .rsp_slope_x  (slope_x),
      .rsp_slope_z  (slope_z),
      .rsp_stepped  (stepped),
      .rsp_oor      (out_of_range)
   );

   assign rsp_tdata = {6'b0, slope_z, slope_x, height};
   assign rsp_tuser = {out_of_range, stepped};

endmodule

### design/whfs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module whfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/whfs_ctrl.sv
// Sequencer for clearing, grid update, slope pass, disturb and report.
module whfs_ctrl
   import whfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_U_RD,
      ST_U_WAIT,
      ST_U_MUL,
      ST_U_SUM,
      ST_U_WR,
      ST_SWAP,
      ST_S_RD,
      ST_S_WR,
      ST_D_RD,
      ST_D_WR,
      ST_RPT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.mode)
               MODE_TICK: begin
                  cmd.tick_upd = 1'b1;
                  if (stat.trigger) begin
                     cmd.pt_init = 1'b1;
                     cmd.sub_clr = 1'b1;
                     state_in    = ST_U_RD;
                  end else begin
                     state_in = ST_RPT;
                  end
               end
               MODE_DISTURB: begin
                  if (stat.in_range) begin
                     cmd.sub_clr = 1'b1;
                     state_in    = ST_D_RD;
                  end else begin
                     cmd.set_oor = 1'b1;
                     state_in    = ST_RPT;
                  end
               end
               MODE_READ: state_in = ST_RPT;
               default:   state_in = ST_RPT;
            endcase
         end
         ST_U_RD: begin
            cmd.rd_sel = RD_UPD;
            if (stat.sub_idx == SUB_UPD_LAST) begin
               cmd.sub_clr = 1'b1;
               state_in    = ST_U_WAIT;
            end else begin
               cmd.sub_inc = 1'b1;
            end
         end
         ST_U_WAIT: state_in = ST_U_MUL;
         ST_U_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_U_SUM;
         end
         ST_U_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            cmd.upd_wr = 1'b1;
            cmd.pt_inc = 1'b1;
            state_in   = stat.pt_last ? ST_SWAP : ST_U_RD;
         end
         ST_SWAP: begin
            cmd.swap    = 1'b1;
            cmd.pt_init = 1'b1;
            cmd.sub_clr = 1'b1;
            state_in    = ST_S_RD;
         end
         ST_S_RD: begin
            cmd.rd_sel = RD_SLP;
            if (stat.sub_idx == SUB_SLP_LAST) begin
               cmd.sub_clr = 1'b1;
               state_in    = ST_S_WR;
            end else begin
               cmd.sub_inc = 1'b1;
            end
         end
         ST_S_WR: begin
            cmd.pt_inc = 1'b1;
            state_in   = stat.pt_last ? ST_RPT : ST_S_RD;
         end
         ST_D_RD: begin
            cmd.rd_sel = RD_DIST;
            state_in   = ST_D_WR;
         end
         ST_D_WR: begin
            if (stat.sub_idx == SUB_DIST_LAST) begin
               state_in = ST_RPT;
            end else begin
               cmd.sub_inc = 1'b1;
               state_in    = ST_D_RD;
            end
         end
         ST_RPT: begin
            // hold until the output word has been taken
            if (!stat.out_busy) begin
               cmd.rd_sel = RD_ITEM;
               state_in   = ST_OUT;
            end
         end
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### design/whfs_datapath.sv
// Height banks, slope stores, weights, accumulator and arithmetic of the unit.
module whfs_datapath
   import whfs_pkg::*;
#(
   parameter int ROWS        = 128,
   parameter int COLS        = 128,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [1:0]            csr_addr,
   input  logic [KW-1:0]         csr_wdata,
   input  logic [1:0]            item_mode,
   input  logic [15:0]           item_elapsed,
   input  logic [6:0]            item_row,
   input  logic [6:0]            item_col,
   input  logic signed [15:0]    item_amount,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_height,
   output logic signed [16:0]    rsp_slope_x,
   output logic signed [16:0]    rsp_slope_z,
   output logic                  rsp_stepped,
   output logic                  rsp_oor
);

   localparam int HB    = HEIGHT_BITS;
   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam int EW    = ((HB > 16) ? HB : 16) + 1;
   localparam int NW    = HB + 2;
   localparam int ACW   = HB + 22;
   localparam int SHW   = ACW - 14;
   localparam int PW    = AW + 8;

   localparam logic [AW-1:0] CO = AW'(COLS);

   localparam logic signed [EW-1:0] E_HMAX   = {{(EW-HB+1){1'b0}}, {(HB-1){1'b1}}};
   localparam logic signed [EW-1:0] E_HMIN   = ~E_HMAX;
   localparam logic signed [EW-1:0] E_S17MAX = {{(EW-16){1'b0}}, {16{1'b1}}};
   localparam logic signed [EW-1:0] E_S17MIN = ~E_S17MAX;
   localparam logic signed [EW-1:0] E_S16MAX = {{(EW-15){1'b0}}, {15{1'b1}}};
   localparam logic signed [EW-1:0] E_S16MIN = ~E_S16MAX;
   localparam logic signed [SHW-1:0] S_HMAX  = {{(SHW-HB+1){1'b0}}, {(HB-1){1'b1}}};
   localparam logic signed [SHW-1:0] S_HMIN  = ~S_HMAX;
   localparam logic signed [ACW-1:0] ROUND_HALF = ACW'(8192);

   function automatic logic signed [HB-1:0] sat_e_h(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = v;
      if (v > E_HMAX) r = E_HMAX;
      else if (v < E_HMIN) r = E_HMIN;
      return r[HB-1:0];
   endfunction

   function automatic logic signed [16:0] sat_e_17(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = v;
      if (v > E_S17MAX) r = E_S17MAX;
      else if (v < E_S17MIN) r = E_S17MIN;
      return r[16:0];
   endfunction

   function automatic logic signed [15:0] sat_e_16(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = v;
      if (v > E_S16MAX) r = E_S16MAX;
      else if (v < E_S16MIN) r = E_S16MIN;
      return r[15:0];
   endfunction

   function automatic logic signed [HB-1:0] sat_s_h(input logic signed [SHW-1:0] v);
      logic signed [SHW-1:0] r;
      r = v;
      if (v > S_HMAX) r = S_HMAX;
      else if (v < S_HMIN) r = S_HMIN;
      return r[HB-1:0];
   endfunction

   // centre, right, left, below, above
   function automatic logic [AW-1:0] dist_addr(input logic [AW-1:0] base,
                                               input logic [2:0] idx);
      logic [AW-1:0] a;
      case (idx)
         3'd0:    a = base;
         3'd1:    a = base + AW'(1);
         3'd2:    a = base - AW'(1);
         3'd3:    a = base + CO;
         default: a = base - CO;
      endcase
      return a;
   endfunction

   // configuration
   logic signed [KW-1:0] kp_ff, kc_ff, kn_ff;
   logic [TSW-1:0]       ts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= K_PREV_RST;
         kc_ff <= K_CENTER_RST;
         kn_ff <= K_NEIGHBOR_RST;
         ts_ff <= TIME_STEP_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_K_PREV:     kp_ff <= $signed(csr_wdata);
            REG_K_CENTER:   kc_ff <= $signed(csr_wdata);
            REG_K_NEIGHBOR: kn_ff <= $signed(csr_wdata);
            REG_TIME_STEP:  ts_ff <= csr_wdata[TSW-1:0];
            default: ;
         endcase
      end
   end

   // latched item
   logic [1:0]         mode_ff;
   logic [15:0]        elapsed_ff;
   logic [6:0]         row_ff, col_ff;
   logic signed [15:0] amt_ff;
   logic               stepped_ff, oor_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff    <= item_mode;
         elapsed_ff <= item_elapsed;
         row_ff     <= item_row;
         col_ff     <= item_col;
         amt_ff     <= item_amount;
      end
   end

   // time accumulator
   logic [31:0] acc_ff;
   logic [32:0] acc_sum;
   logic [31:0] acc_sat;
   logic        trigger;

   assign acc_sum = {1'b0, acc_ff} + 33'(elapsed_ff);
   assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
   assign trigger = (acc_sat >= 32'(ts_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.tick_upd) begin
         acc_ff <= trigger ? '0 : acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         stepped_ff <= 1'b0;
         oor_ff     <= 1'b0;
      end else begin
         if (cmd.tick_upd && trigger) stepped_ff <= 1'b1;
         if (cmd.set_oor) oor_ff <= 1'b1;
      end
   end

   // control counters
   logic          bank_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [2:0]    sub_ff, sub_d_ff;
   rd_sel_type    rd_sel_ff;
   logic [RW-1:0] pi_ff;
   logic [CW-1:0] pj_ff;
   logic [AW-1:0] p_ff;
   logic          pt_last;

   assign pt_last = (pi_ff == RW'(ROWS - 2)) && (pj_ff == CW'(COLS - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff    <= 1'b0;
         clr_cnt_ff <= '0;
         sub_ff     <= '0;
         sub_d_ff   <= '0;
         rd_sel_ff  <= RD_NONE;
         pi_ff      <= RW'(1);
         pj_ff      <= CW'(1);
         p_ff       <= AW'(COLS + 1);
      end else begin
         if (cmd.swap) bank_ff <= ~bank_ff;
         if (cmd.clr_wr) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (cmd.sub_clr) sub_ff <= '0;
         else if (cmd.sub_inc) sub_ff <= sub_ff + 3'd1;
         sub_d_ff  <= sub_ff;
         rd_sel_ff <= cmd.rd_sel;
         if (cmd.pt_init) begin
            pi_ff <= RW'(1);
            pj_ff <= CW'(1);
            p_ff  <= AW'(COLS + 1);
         end else if (cmd.pt_inc) begin
            // skip the right and left boundary columns at a row end
            if (pj_ff == CW'(COLS - 2)) begin
               pj_ff <= CW'(1);
               pi_ff <= pi_ff + RW'(1);
               p_ff  <= p_ff + AW'(3);
            end else begin
               pj_ff <= pj_ff + CW'(1);
               p_ff  <= p_ff + AW'(1);
            end
         end
      end
   end

   // item address and range checks
   logic [PW-1:0] ip_full;
   logic [AW-1:0] ip;
   logic          in_grid, in_range;

   assign ip_full  = PW'(row_ff) * PW'(COLS) + PW'(col_ff);
   assign ip       = ip_full[AW-1:0];
   assign in_grid  = (int'(row_ff) < ROWS) && (int'(col_ff) < COLS);
   assign in_range = (row_ff >= 7'd2) && (int'(row_ff) + 3 <= ROWS) &&
                     (col_ff >= 7'd2) && (int'(col_ff) + 3 <= COLS);

   // memories
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        h_wa, s_wa;
   logic signed [HB-1:0] h_wd;
   logic signed [16:0]   sx_wd, sz_wd;
   logic                 we_a, we_b, we_s;
   logic [HB-1:0]        ha_q, hb_q;
   logic [16:0]          sx_q, sz_q;
   logic signed [HB-1:0] cur_q, prv_q;

   assign cur_q = bank_ff ? $signed(hb_q) : $signed(ha_q);
   assign prv_q = bank_ff ? $signed(ha_q) : $signed(hb_q);

   always_comb begin
      case (cmd.rd_sel)
         RD_UPD: begin
            case (sub_ff)
               3'd0:    rd_addr = p_ff - AW'(1);
               3'd1:    rd_addr = p_ff + AW'(1);
               3'd2:    rd_addr = p_ff - CO;
               3'd3:    rd_addr = p_ff + CO;
               default: rd_addr = p_ff;
            endcase
         end
         RD_SLP: begin
            case (sub_ff)
               3'd0:    rd_addr = p_ff - AW'(1);
               3'd1:    rd_addr = p_ff + AW'(1);
               3'd2:    rd_addr = p_ff - CO;
               default: rd_addr = p_ff + CO;
            endcase
         end
         RD_DIST: rd_addr = dist_addr(ip, sub_ff);
         RD_ITEM: rd_addr = ip;
         default: rd_addr = '0;
      endcase
   end

   // arithmetic registers
   logic signed [NW-1:0]      nsum_ff;
   logic signed [HB-1:0]      c_ff, pv_ff, l_ff, r_ff, u_ff, new_ff;
   logic signed [KW+HB-1:0]   prod_p_ff, prod_c_ff;
   logic signed [KW+NW-1:0]   prod_n_ff;
   logic signed [ACW-1:0]     acc_all;
   logic signed [SHW-1:0]     acc_sh;
   logic signed [15:0]        half_amt, add_amt;
   logic signed [HB-1:0]      dist_sat;

   assign acc_all = ACW'(prod_p_ff) + ACW'(prod_c_ff) + ACW'(prod_n_ff) + ROUND_HALF;
   assign acc_sh  = $signed(acc_all[ACW-1:14]);

   assign half_amt = amt_ff >>> 1;
   assign add_amt  = (sub_d_ff == 3'd0) ? amt_ff : half_amt;
   assign dist_sat = sat_e_h(EW'(cur_q) + EW'(add_amt));

   always_ff @(posedge clock) begin
      case (rd_sel_ff)
         RD_UPD: begin
            if (sub_d_ff == 3'd0) begin
               nsum_ff <= NW'(cur_q);
            end else if (sub_d_ff == SUB_UPD_LAST) begin
               c_ff  <= cur_q;
               pv_ff <= prv_q;
            end else begin
               nsum_ff <= nsum_ff + NW'(cur_q);
            end
         end
         RD_SLP: begin
            case (sub_d_ff)
               3'd0:    l_ff <= cur_q;
               3'd1:    r_ff <= cur_q;
               3'd2:    u_ff <= cur_q;
               default: ;
            endcase
         end
         default: ;
      endcase
      if (cmd.mul) begin
         prod_p_ff <= kp_ff * pv_ff;
         prod_c_ff <= kc_ff * c_ff;
         prod_n_ff <= kn_ff * nsum_ff;
      end
      if (cmd.sum) begin
         new_ff <= sat_s_h(acc_sh);
      end
   end

   // write ports
   logic dist_we, slope_we;

   assign dist_we  = (rd_sel_ff == RD_DIST);
   assign slope_we = (rd_sel_ff == RD_SLP) && (sub_d_ff == SUB_SLP_LAST);

   always_comb begin
      h_wa  = p_ff;
      h_wd  = new_ff;
      we_a  = 1'b0;
      we_b  = 1'b0;
      s_wa  = p_ff;
      sx_wd = sat_e_17(EW'(l_ff) - EW'(r_ff));
      sz_wd = sat_e_17(EW'(cur_q) - EW'(u_ff));
      we_s  = slope_we;
      if (cmd.clr_wr) begin
         h_wa  = clr_cnt_ff;
         h_wd  = '0;
         we_a  = 1'b1;
         we_b  = 1'b1;
         s_wa  = clr_cnt_ff;
         sx_wd = '0;
         sz_wd = '0;
         we_s  = 1'b1;
      end else if (cmd.upd_wr) begin
         // new heights overwrite the previous bank
         we_a = bank_ff;
         we_b = ~bank_ff;
      end else if (dist_we) begin
         h_wa = dist_addr(ip, sub_d_ff);
         h_wd = dist_sat;
         we_a = ~bank_ff;
         we_b = bank_ff;
      end
   end

   whfs_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_bank_a (
      .clock   (clock),
      .we      (we_a),
      .wr_addr (h_wa),
      .wr_data (h_wd),
      .rd_addr (rd_addr),
      .rd_data (ha_q)
   );

   whfs_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_bank_b (
      .clock   (clock),
      .we      (we_b),
      .wr_addr (h_wa),
      .wr_data (h_wd),
      .rd_addr (rd_addr),
      .rd_data (hb_q)
   );

   whfs_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_slope_x (
      .clock   (clock),
      .we      (we_s),
      .wr_addr (s_wa),
      .wr_data (sx_wd),
      .rd_addr (rd_addr),
      .rd_data (sx_q)
   );

   whfs_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_slope_z (
      .clock   (clock),
      .we      (we_s),
      .wr_addr (s_wa),
      .wr_data (sz_wd),
      .rd_addr (rd_addr),
      .rd_data (sz_q)
   );

   // output word
   logic               rsp_valid_ff;
   logic signed [15:0] h_out_ff;
   logic signed [16:0] sx_out_ff, sz_out_ff;
   logic               st_out_ff, oor_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rd_sel_ff == RD_ITEM) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_sel_ff == RD_ITEM) begin
         h_out_ff   <= in_grid ? sat_e_16(EW'(cur_q)) : '0;
         sx_out_ff  <= in_grid ? $signed(sx_q) : '0;
         sz_out_ff  <= in_grid ? $signed(sz_q) : '0;
         st_out_ff  <= stepped_ff;
         oor_out_ff <= oor_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_height  = h_out_ff;
   assign rsp_slope_x = sx_out_ff;
   assign rsp_slope_z = sz_out_ff;
   assign rsp_stepped = st_out_ff;
   assign rsp_oor     = oor_out_ff;

   assign stat.mode     = mode_ff;
   assign stat.trigger  = trigger;
   assign stat.in_range = in_range;
   assign stat.pt_last  = pt_last;
   assign stat.clr_last = (clr_cnt_ff == AW'(DEPTH - 1));
   assign stat.out_busy = rsp_valid_ff;
   assign stat.sub_idx  = sub_ff;

endmodule

### design/whfs_checker.sv
// Port-level checker for the wave height field step unit, bound to the top.
module whfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // the unit clears its memories after reset before taking words
   a_reset_not_ready: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // one word at a time: not ready in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted word");

   // no word is both a stepped tick and a refused disturb
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones(rsp_tuser) <= 1))
      else $error("stepped and out_of_range both set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("rsp word changed while stalled");

endmodule

bind wave_height_field_step_unit whfs_checker u_whfs_checker (.*);

### verif/tb_wave_height_field_step_unit.sv
// Self-checking testbench for the wave height field step unit.
`timescale 1ns / 100ps

module tb_wave_height_field_step_unit;
   import whfs_pkg::*;

   localparam int NR = 128;
   localparam int NC = 128;
   localparam int HB = 16;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct {
      logic signed [15:0] height;
      logic signed [16:0] slope_x;
      logic signed [16:0] slope_z;
      logic               stepped;
      logic               oor;
   } wave_point_type;

   class wave_field_scoreboard;
      int             bank [2][NR*NC];
      int             sx_store [NR*NC];
      int             sz_store [NR*NC];
      bit             cur_bank;
      longint         accum;
      int             k_prv, k_ctr, k_nbr;
      int             t_step;
      wave_point_type pending [$];
      int             errors;

      function new();
         foreach (bank[b, p]) bank[b][p] = 0;
         foreach (sx_store[p]) begin
            sx_store[p] = 0;
            sz_store[p] = 0;
         end
         cur_bank = 0;
         accum = 0;
         k_prv = K_PREV_RST;
         k_ctr = K_CENTER_RST;
         k_nbr = K_NEIGHBOR_RST;
         t_step = TIME_STEP_RST;
         errors = 0;
      endfunction

      function longint clip(longint v, int bits);
         longint hi;
         hi = (longint'(1) << (bits - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      function void set_reg(logic [1:0] idx, logic [KW-1:0] val);
         case (idx)
            REG_K_PREV:     k_prv = int'($signed(val));
            REG_K_CENTER:   k_ctr = int'($signed(val));
            REG_K_NEIGHBOR: k_nbr = int'($signed(val));
            REG_TIME_STEP:  t_step = int'(val[TSW-1:0]);
            default: ;
         endcase
      endfunction

      function void sweep_grid();
         int     c, q, p;
         longint nsum, acc;
         c = cur_bank;
         q = 1 - c;
         for (int i = 1; i < NR - 1; i++)
            for (int j = 1; j < NC - 1; j++) begin
               p = i * NC + j;
               nsum = longint'(bank[c][p+NC]) + bank[c][p-NC] + bank[c][p+1] + bank[c][p-1];
               acc = longint'(k_prv) * bank[q][p] + longint'(k_ctr) * bank[c][p]
                     + longint'(k_nbr) * nsum;
               bank[q][p] = int'(clip((acc + 8192) >>> 14, HB));
            end
         cur_bank = ~cur_bank;
         c = cur_bank;
         for (int i = 1; i < NR - 1; i++)
            for (int j = 1; j < NC - 1; j++) begin
               p = i * NC + j;
               sx_store[p] = int'(clip(longint'(bank[c][p-1]) - bank[c][p+1], 17));
               sz_store[p] = int'(clip(longint'(bank[c][p+NC]) - bank[c][p-NC], 17));
            end
      endfunction

      function void bump(int p, longint amt);
         bank[cur_bank][p] = int'(clip(longint'(bank[cur_bank][p]) + amt, HB));
      endfunction

      // Predict the result of one accepted input word.
      function void note_word(logic [1:0] mode, logic [15:0] elapsed, logic [6:0] row,
                              logic [6:0] col, logic signed [15:0] amt);
         wave_point_type w;
         int             p;
         longint         half;
         w.stepped = 0;
         w.oor = 0;
         p = int'(row) * NC + int'(col);
         if (mode == MODE_TICK) begin
            accum = accum + elapsed;
            if (accum > 64'hFFFF_FFFF) accum = 64'hFFFF_FFFF;
            if (accum >= t_step) begin
               accum = 0;
               sweep_grid();
               w.stepped = 1;
            end
         end else if (mode == MODE_DISTURB) begin
            if (row >= 2 && row <= NR - 3 && col >= 2 && col <= NC - 3) begin
               half = longint'(amt) >>> 1;
               bump(p, amt);
               bump(p + 1, half);
               bump(p - 1, half);
               bump(p + NC, half);
               bump(p - NC, half);
            end else w.oor = 1;
         end
         w.height = 16'(clip(bank[cur_bank][p], 16));
         w.slope_x = 17'(sx_store[p]);
         w.slope_z = 17'(sz_store[p]);
         pending.push_back(w);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_word(logic [55:0] data, logic [1:0] user);
         wave_point_type w;
         if (pending.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
         end
         w = pending.pop_front();
         if ($signed(data[15:0]) != w.height)
            report("height", $signed(data[15:0]), w.height);
         if ($signed(data[32:16]) != w.slope_x)
            report("slope_x", $signed(data[32:16]), w.slope_x);
         if ($signed(data[49:33]) != w.slope_z)
            report("slope_z", $signed(data[49:33]), w.slope_z);
         if (user[0] != w.stepped) report("stepped", user[0], w.stepped);
         if (user[1] != w.oor) report("out_of_range", user[1], w.oor);
      endtask
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [55:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_wen = 0;
   logic [1:0]    csr_addr = '0;
   logic [KW-1:0] csr_wdata = '0;

   wave_field_scoreboard sb = new();
   longint cycles = 0;
   bit     quiet = 0;
   bit     hold_req = 0;
   int     hold_cnt = 0;
   int     stall_cnt = 0;
   int     steps_left = 2;

   wave_height_field_step_unit DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: check, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser);
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 0;
      end else if (hold_req) begin
         hold_req = 0;
         hold_cnt = 400;
         rsp_tready <= 0;
      end else if (quiet) begin
         rsp_tready <= 1;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_cnt = $urandom_range(0, 17);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   task send_word(logic [1:0] mode, logic [15:0] elapsed, logic [6:0] row, logic [6:0] col,
                  logic [15:0] amt);
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {2'b00, amt, col, row, elapsed};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(mode, elapsed, row, col, amt);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [KW-1:0] val);
      csr_wen <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_wen <= 0;
      @(posedge clock);
   endtask

   task rand_word();
      int          r;
      logic [6:0]  row, col;
      longint      room;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
         row = 7'($urandom_range(58, 70));
         col = 7'($urandom_range(58, 70));
      end else begin
         row = 7'($urandom_range(0, 127));
         col = 7'($urandom_range(0, 127));
      end
      if (r < 35) begin
         send_word(MODE_DISTURB, 16'($urandom), row, col, 16'($urandom));
      end else if (r < 70) begin
         send_word(r < 62 ? MODE_READ : MODE_SPARE, 16'($urandom), row, col, 16'($urandom));
      end else if (steps_left > 0 && $urandom_range(0, 19) == 0) begin
         steps_left--;
         send_word(MODE_TICK, 16'hFFFF, row, col, 16'($urandom));
      end else begin
         // keep the accumulator below the step so sweeps stay rare
         room = longint'(sb.t_step) - sb.accum;
         send_word(MODE_TICK, room > 1 ? 16'($urandom_range(0, int'(room) - 1)) : 16'h0,
                   row, col, 16'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: edges of the fields, saturation, refused disturbs, one sweep
      send_word(MODE_READ, 16'h0, 7'd0, 7'd0, 16'h0);
      send_word(MODE_SPARE, 16'h0, 7'd127, 7'd127, 16'h0);
      send_word(MODE_DISTURB, 16'h0, 7'd64, 7'd64, 16'h7FFF);
      send_word(MODE_DISTURB, 16'h0, 7'd64, 7'd64, 16'h7FFF);
      send_word(MODE_DISTURB, 16'h0, 7'd64, 7'd65, 16'h8000);
      send_word(MODE_DISTURB, 16'h0, 7'd2, 7'd2, 16'hFFFF);
      send_word(MODE_DISTURB, 16'h0, 7'd125, 7'd125, 16'd100);
      send_word(MODE_DISTURB, 16'h0, 7'd1, 7'd64, 16'd500);
      send_word(MODE_DISTURB, 16'h0, 7'd64, 7'd126, 16'd500);
      send_word(MODE_DISTURB, 16'h0, 7'd127, 7'd0, 16'd500);
      send_word(MODE_READ, 16'h0, 7'd63, 7'd64, 16'h0);
      send_word(MODE_TICK, 16'h0, 7'd64, 7'd64, 16'h0);
      send_word(MODE_TICK, 16'd29, 7'd64, 7'd64, 16'h0);
      send_word(MODE_TICK, 16'd1, 7'd64, 7'd64, 16'h0);
      send_word(MODE_READ, 16'h0, 7'd64, 7'd63, 16'h0);
      send_word(MODE_READ, 16'h0, 7'd65, 7'd64, 16'h0);
      drain();

      // extreme weights and the shortest step
      write_reg(REG_K_PREV, 18'h20000);
      write_reg(REG_K_CENTER, 18'h1FFFF);
      write_reg(REG_K_NEIGHBOR, 18'h1FFFF);
      write_reg(REG_TIME_STEP, 18'd1);
      send_word(MODE_DISTURB, 16'h0, 7'd30, 7'd30, 16'h4000);
      send_word(MODE_TICK, 16'hFFFF, 7'd30, 7'd30, 16'h0);
      send_word(MODE_READ, 16'h0, 7'd30, 7'd31, 16'h0);
      send_word(MODE_READ, 16'h0, 7'd29, 7'd30, 16'h0);
      drain();

      // random previous and centre weights, most negative neighbour weight, longest step
      write_reg(REG_K_PREV, 18'h20000 | 18'($urandom_range(0, 16383)));
      write_reg(REG_K_CENTER, 18'($urandom_range(8192, 24576)));
      write_reg(REG_K_NEIGHBOR, 18'h20000);
      write_reg(REG_TIME_STEP, 18'hFFFF);
      for (int n = 0; n < 100; n++) begin
         if (n == 30) hold_req = 1;
         if (n == 55) drain();
         if (n == 80) quiet = 1;
         rand_word();
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### wave_height_field_step_unit.f
design/whfs_pkg.sv
design/whfs_ram.sv
design/whfs_ctrl.sv
design/whfs_datapath.sv
design/wave_height_field_step_unit.sv
design/whfs_checker.sv
verif/tb_wave_height_field_step_unit.sv
